### hw/rtl/supersample_box_resolve_core_defines.svh
// Assertion macros shared by the supersample box resolve RTL.
`ifndef SUPERSAMPLE_BOX_RESOLVE_CORE_DEFINES_SVH
`define SUPERSAMPLE_BOX_RESOLVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SSBR_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define SSBR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ssbr_pkg.sv
// Types and fixed constants of the supersample box resolve block.
`timescale 1ns / 1ps

package ssbr_pkg;

   // Field widths fixed by the interface.
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 16;
   localparam int POS_W      = 11;
   localparam int CFG_RATE_W = 3;
   localparam int CFG_SIZE_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_LANES  = 4;
   localparam int MAX_HEIGHT = 2048;
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RATE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_HEIGHT = 2'd2;

   // Register reset values.
   localparam logic [CFG_RATE_W-1:0] RATE_RESET         = 3'd1;
   localparam logic [CFG_SIZE_W-1:0] PIXEL_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_SIZE_W-1:0] PIXEL_HEIGHT_RESET = 12'd480;

   // Largest value an averaged channel may take.
   localparam logic [SUM_W-1:0] CHAN_MAX = 16'd255;

   typedef struct packed {
      logic [CHAN_W-1:0] sample_r;
      logic [CHAN_W-1:0] sample_g;
      logic [CHAN_W-1:0] sample_b;
      logic [CHAN_W-1:0] sample_a;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_r;
      logic [CHAN_W-1:0] out_g;
      logic [CHAN_W-1:0] out_b;
      logic [CHAN_W-1:0] out_a;
      logic [POS_W-1:0]  pixel_col;
      logic [POS_W-1:0]  pixel_row;
      logic              frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CFG_SIZE_W-1:0] wdata;
   } csr_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic acc;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic pixel_done;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/ssbr_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface ssbr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ssbr_ctrl.sv
// Controller state machine of the supersample box resolve block.
`timescale 1ns / 1ps

module ssbr_ctrl import ssbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output logic          req_ready,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = status.pixel_done ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.acc      = (state_ff == ST_ACC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.emit     = (state_ff == ST_EMIT) && status.out_free;
   end

endmodule

### hw/rtl/ssbr_datapath.sv
// Datapath: configuration, position counters, sum memory, divider, output register.
`timescale 1ns / 1ps

module ssbr_datapath import ssbr_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RATE  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  req_payload_type       req_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_SIZE_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_RATE + 1);
   localparam int RCW   = (RW > CFG_RATE_W) ? RW : CFG_RATE_W;
   localparam int SW    = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
   localparam int NW    = 2 * RCW;
   localparam int WCW   = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
   localparam int MEM_W = NUM_LANES * SUM_W;

   // Configuration registers.
   logic [CFG_RATE_W-1:0] rate_ff;
   logic [CFG_SIZE_W-1:0] width_ff;
   logic [CFG_SIZE_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RESET;
         width_ff  <= PIXEL_WIDTH_RESET;
         height_ff <= PIXEL_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:         rate_ff   <= csr_wdata[CFG_RATE_W-1:0];
            CSR_PIXEL_WIDTH:  width_ff  <= csr_wdata;
            CSR_PIXEL_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Out-of-range settings clamp into their legal range.
   logic [RCW-1:0]        rate_ext;
   logic [WCW-1:0]        width_ext;
   logic [RCW-1:0]        r_eff;
   logic [WCW-1:0]        w_eff;
   logic [CFG_SIZE_W-1:0] h_eff;

   always_comb begin
      rate_ext  = RCW'(rate_ff);
      width_ext = WCW'(width_ff);
      if (rate_ext == '0) begin
         r_eff = RCW'(1);
      end else if (rate_ext > RCW'(MAX_RATE)) begin
         r_eff = RCW'(MAX_RATE);
      end else begin
         r_eff = rate_ext;
      end
      if (width_ext == '0) begin
         w_eff = WCW'(1);
      end else if (width_ext > WCW'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = width_ext;
      end
      if (height_ff == '0) begin
         h_eff = CFG_SIZE_W'(1);
      end else if (height_ff > CFG_SIZE_W'(MAX_HEIGHT)) begin
         h_eff = CFG_SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Position counters.
   logic [SW-1:0]    sub_col_ff, sub_col_in;
   logic [SW-1:0]    sub_row_ff, sub_row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic             last_sc, last_sr, last_c, last_r;

   assign last_sc = (RCW'(sub_col_ff) + RCW'(1)) >= r_eff;
   assign last_sr = (RCW'(sub_row_ff) + RCW'(1)) >= r_eff;
   assign last_c  = (WCW'(col_ff) + WCW'(1)) >= w_eff;
   assign last_r  = (CFG_SIZE_W'(row_ff) + CFG_SIZE_W'(1)) >= h_eff;

   // Raster walk: sub-column, column, sub-row, row.
   always_comb begin
      sub_col_in = sub_col_ff;
      sub_row_in = sub_row_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      if (!last_sc) begin
         sub_col_in = sub_col_ff + SW'(1);
      end else begin
         sub_col_in = '0;
         if (!last_c) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            if (!last_sr) begin
               sub_row_in = sub_row_ff + SW'(1);
            end else begin
               sub_row_in = '0;
               row_in     = last_r ? '0 : row_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff <= '0;
         sub_row_ff <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else if (cmd.acc) begin
         sub_col_ff <= sub_col_in;
         sub_row_ff <= sub_row_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

   // Clearing pass address after reset.
   logic [CW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + CW'(1);
      end
   end

   // Sample captured at acceptance.
   logic [CHAN_W-1:0] sample_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff[0] <= req_payload.sample_r;
         sample_ff[1] <= req_payload.sample_g;
         sample_ff[2] <= req_payload.sample_b;
         sample_ff[3] <= req_payload.sample_a;
      end
   end

   // Saturating accumulate of the sample into the column's sums; the sums are zeroed when the sample finishes a pixel.
   logic [MEM_W-1:0] rd_data_ff;
   logic [SUM_W-1:0] sat_sum [NUM_LANES];
   logic [MEM_W-1:0] acc_wdata;

   always_comb begin
      logic [SUM_W:0] sum_wide;
      for (int l = 0; l < NUM_LANES; l++) begin
         sum_wide   = {1'b0, rd_data_ff[l*SUM_W +: SUM_W]} + (SUM_W + 1)'(sample_ff[l]);
         sat_sum[l] = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         acc_wdata[l*SUM_W +: SUM_W] = status.pixel_done ? '0 : sat_sum[l];
      end
   end

   // Column sum memory: one write port, one registered read port.
   logic [MEM_W-1:0] sums_mem [MAX_WIDTH];
   logic             mem_we;
   logic [CW-1:0]    mem_waddr;
   logic [MEM_W-1:0] mem_wdata;

   assign mem_we    = cmd.clear_wr || cmd.acc;
   assign mem_waddr = cmd.clear_wr ? clr_addr_ff : col_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : acc_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_data_ff <= sums_mem[col_ff];
      end
   end

   // Restoring divider, one quotient bit per cycle in all four lanes.
   logic [SUM_W-1:0]     div_quo_ff [NUM_LANES];
   logic [NW-1:0]        div_rem_ff [NUM_LANES];
   logic [SUM_W-1:0]     div_quo_in [NUM_LANES];
   logic [NW-1:0]        div_rem_in [NUM_LANES];
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [NW-1:0]        divisor_ff;
   logic [POS_W-1:0]     pend_col_ff;
   logic [POS_W-1:0]     pend_row_ff;
   logic                 pend_end_ff;

   always_comb begin
      logic [NW:0] part;
      logic [NW:0] diff;
      logic        ge;
      for (int l = 0; l < NUM_LANES; l++) begin
         part          = {div_rem_ff[l], div_quo_ff[l][SUM_W-1]};
         diff          = part - {1'b0, divisor_ff};
         ge            = part >= {1'b0, divisor_ff};
         div_rem_in[l] = ge ? diff[NW-1:0] : part[NW-1:0];
         div_quo_in[l] = {div_quo_ff[l][SUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc && status.pixel_done) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            div_quo_ff[l] <= sat_sum[l];
            div_rem_ff[l] <= '0;
         end
         div_cnt_ff  <= '0;
         divisor_ff  <= r_eff * r_eff;
         pend_col_ff <= POS_W'(col_ff);
         pend_row_ff <= row_ff;
         pend_end_ff <= last_c && last_r;
      end else if (cmd.div_step) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            div_quo_ff[l] <= div_quo_in[l];
            div_rem_ff[l] <= div_rem_in[l];
         end
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Output register; averages above the channel range saturate.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   logic [CHAN_W-1:0] avg_sat [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         avg_sat[l] = (div_quo_ff[l] > CHAN_MAX) ? '1 : div_quo_ff[l][CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff.out_r     <= avg_sat[0];
         rsp_payload_ff.out_g     <= avg_sat[1];
         rsp_payload_ff.out_b     <= avg_sat[2];
         rsp_payload_ff.out_a     <= avg_sat[3];
         rsp_payload_ff.pixel_col <= pend_col_ff;
         rsp_payload_ff.pixel_row <= pend_row_ff;
         rsp_payload_ff.frame_end <= pend_end_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Status back to the controller.
   always_comb begin
      status.clear_last = (clr_addr_ff == CW'(MAX_WIDTH - 1));
      status.pixel_done = last_sc && last_sr;
      status.div_last   = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

### hw/rtl/supersample_box_resolve_core.sv
// Supersample box resolve: averages each pixel's rate x rate RGBA samples.
//
// The req_if channel takes one RGBA supersample per transaction, in raster order over
// a frame of (pixel_width * rate) x (pixel_height * rate) samples. The rsp_if channel
// gives one averaged pixel, with its column, row and an end-of-frame flag, for the
// last sample of every pixel. The csr_if channel writes rate (index 0), pixel_width
// (index 1) and pixel_height (index 2); it is always ready. It is to be written only
// while idle, which the block itself does not enforce. A sample that does not finish
// a pixel passes through the idle and accumulate states: the column's sums are read
// from the sum memory, then added to and written back on its single write port.
// A sample that finishes a pixel then steps through the bit-serial divider and loads
// the output register. After reset the sum memory is cleared, one column a cycle,
// through all MAX_WIDTH columns (2048 by default) before the first sample is taken.
// Reset also restores the register defaults and the position counters.
// The result sits in an output register until taken; the next sample is accepted
// meanwhile, and only a following finished pixel waits for the register to free up.
`timescale 1ns / 1ps
`include "supersample_box_resolve_core_defines.svh"

module supersample_box_resolve_core import ssbr_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RATE  = 4
) (
   input logic            clock,
   input logic            reset,
   ssbr_stream_if.sink    req_if,
   ssbr_stream_if.source  rsp_if,
   ssbr_stream_if.sink    csr_if
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          csr_we;

   // The register file takes a write in any cycle.
   assign csr_if.ready = 1'b1;
   assign csr_we       = csr_if.valid && csr_if.ready;
   assign req_if.ready = req_ready;

   ssbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ssbr_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_RATE  (MAX_RATE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_if.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_if.payload.reg_index),
      .csr_wdata   (csr_if.payload.wdata),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_if.payload)
   );

   // Consistency checks between controller and datapath.
   `SSBR_ASSERT_NEXT(a_accept_then_busy, req_if.valid && req_if.ready, !req_if.ready, "sample accepted while previous one is still in work")
   `SSBR_ASSERT_IMPLIES(a_no_accept_in_clear, cmd.clear_wr, !req_if.ready, "sample channel ready during memory clear")
   `SSBR_ASSERT_NEXT(a_div_runs_through, cmd.div_step && !status.div_last, cmd.div_step, "divider stopped before its last step")
   `SSBR_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_if.valid, "loaded result not presented")

endmodule
